// ===== sv/tbn_pkg.sv =====
// Shared types and constants of the triangle tangent and binormal block.
// No dependencies; used by tbn_ctrl, tbn_dp and the top level.
`default_nettype none
package tbn_pkg;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_HOLD,
    OP_LOAD,
    OP_MUL,
    OP_ACC,
    OP_VSEL,
    OP_MAX,
    OP_NORM,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_STORE,
    OP_FIN
  } tbn_op_t;

  typedef struct packed {
    tbn_op_t     op;
    logic [4:0]  k;      // product index
    logic [1:0]  comp;   // vector component or held vertex slot
    logic [4:0]  qbit;   // quotient bit under trial
    logic        vec;    // 0 tangent, 1 binormal
  } tbn_cmd_t;

  typedef struct packed {
    logic degen;
    logic norm_done;
  } tbn_stat_t;

  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned IN_W      = 5 * FIELD_W;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned OUTD_W    = 6 * OUT_W;
  localparam int unsigned LAST_XK   = 13;  // last cross product index
  localparam int unsigned SQ_K0     = 14;  // first square index
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned QBITS     = 17;
  localparam logic [16:0] UNIT_Q14  = 17'd16384;

endpackage
`default_nettype wire

// ===== sv/tbn_ctrl.sv =====
// Controller of the tangent and binormal block: vertex counting, the step
// sequence of the shared datapath and the result handshake. Uses tbn_pkg.
`default_nettype none
module tbn_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire tbn_pkg::tbn_stat_t stat,
  output tbn_pkg::tbn_cmd_t      cmd
);
  import tbn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_CHK, S_VSEL, S_MAX, S_NORM, S_SQM, S_SQA,
    S_SQRT0, S_SQRT, S_DIV0, S_DIV, S_STORE, S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [4:0] bit_r, bit_nxt;
  logic       vec_r, vec_nxt;
  logic       ovld_r, ovld_nxt;
  logic       in_fire;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = ovld_r;

  // Next state and command for the datapath.
  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    cnt_nxt   = cnt_r;
    bit_nxt   = bit_r;
    vec_nxt   = vec_r;
    ovld_nxt  = ovld_r && !out_tready;
    cmd       = '{op: OP_NOP, k: cnt_r, comp: cnt_r[1:0], qbit: bit_r, vec: vec_r};
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (slot_r != 2'd2) begin
            cmd.op   = OP_HOLD;
            cmd.comp = slot_r;
            slot_nxt = slot_r + 2'd1;
          end else begin
            cmd.op    = OP_LOAD;
            slot_nxt  = 2'd0;
            cnt_nxt   = 5'd0;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (cnt_r == 5'(LAST_XK)) begin
          state_nxt = S_CHK;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = S_MUL;
        end
      end
      S_CHK: begin
        vec_nxt   = 1'b0;
        state_nxt = stat.degen ? S_FIN : S_VSEL;
      end
      S_VSEL: begin
        cmd.op    = OP_VSEL;
        cnt_nxt   = 5'd1;
        state_nxt = S_MAX;
      end
      S_MAX: begin
        cmd.op = OP_MAX;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd2) state_nxt = S_NORM;
      end
      S_NORM: begin
        if (stat.norm_done) begin
          cnt_nxt   = 5'd0;
          state_nxt = S_SQM;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      S_SQM: begin
        cmd.op    = OP_MUL;
        cmd.k     = 5'(SQ_K0) + cnt_r;
        state_nxt = S_SQA;
      end
      S_SQA: begin
        cmd.op = OP_ACC;
        cmd.k  = 5'(SQ_K0) + cnt_r;
        if (cnt_r == 5'd2) begin
          state_nxt = S_SQRT0;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = S_SQM;
        end
      end
      S_SQRT0: begin
        cmd.op    = OP_SQRT_INIT;
        cnt_nxt   = 5'd0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op  = OP_SQRT_STEP;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(SQRT_STEPS - 1)) begin
          cnt_nxt   = 5'd0;
          state_nxt = S_DIV0;
        end
      end
      S_DIV0: begin
        cmd.op    = OP_DIV_INIT;
        bit_nxt   = 5'(QBITS - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = OP_DIV_STEP;
        bit_nxt = bit_r - 5'd1;
        if (bit_r == 5'd0) state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.op = OP_STORE;
        if (cnt_r == 5'd2) begin
          if (!vec_r) begin
            vec_nxt   = 1'b1;
            state_nxt = S_VSEL;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = S_DIV0;
        end
      end
      S_FIN: begin
        if (!ovld_r || out_tready) begin
          cmd.op    = OP_FIN;
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r  <= 2'd0;
      cnt_r   <= 5'd0;
      bit_r   <= 5'd0;
      vec_r   <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      cnt_r   <= cnt_nxt;
      bit_r   <= bit_nxt;
      vec_r   <= vec_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_FIN |=> ovld_r) else $error("result beat not raised");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r != 2'd3) else $error("vertex count out of range");
  a_fin_noclobber: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_FIN |-> (!ovld_r || out_tready)) else $error("result overwritten");
  a_busy_noaccept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready) else $error("beat taken while busy");
`endif

endmodule
`default_nettype wire

// ===== sv/tbn_dp.sv =====
// Datapath of the tangent and binormal block: held vertices, shared 32x32
// multiplier, accumulators, normalizing shifter, square root and divider.
// Uses tbn_pkg; driven by tbn_ctrl.
`default_nettype none
module tbn_dp (
  input  wire logic                          clk,
  input  wire tbn_pkg::tbn_cmd_t             cmd,
  input  wire logic [tbn_pkg::IN_W-1:0]      in_tdata,
  output tbn_pkg::tbn_stat_t                 stat,
  output logic [tbn_pkg::OUTD_W-1:0]         out_tdata,
  output logic                               out_tuser
);
  import tbn_pkg::*;

  logic signed [31:0] h0_r [5];
  logic signed [31:0] h1_r [5];
  logic signed [32:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  logic signed [32:0] du0_r, dv0_r, du1_r, dv1_r;
  logic signed [65:0] det_r, tx_r, ty_r, tz_r, bx_r, by_r, bz_r;
  logic [63:0] prod_r;
  logic        psign_r;
  logic [64:0] c_r [3];
  logic        cneg_r [3];
  logic [64:0] mx_r;
  logic [63:0] sum_r, sx_r, sres_r, sbit_r;
  logic [46:0] rem_r;
  logic [16:0] q_r;
  logic [15:0] res_r [6];

  logic signed [31:0] fin [5];
  logic signed [32:0] opa, opb;
  logic               osub;
  logic [31:0]        ma, mb;
  logic signed [65:0] addend;
  logic signed [65:0] vsel [3];
  logic [31:0]        lenu;
  logic [63:0]        strial;
  logic [46:0]        dtrial;
  logic [1:0]         ci;
  logic [15:0]        qv;
  logic               qneg;

  for (genvar g = 0; g < 5; g++) begin : g_in
    assign fin[g] = in_tdata[g*FIELD_W +: FIELD_W];
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    opa = '0; opb = '0; osub = 1'b0;
    unique case (cmd.k)
      5'd0:  begin opa = du0_r; opb = dv1_r; end
      5'd1:  begin opa = du1_r; opb = dv0_r; osub = 1'b1; end
      5'd2:  begin opa = dv1_r; opb = e1x_r; end
      5'd3:  begin opa = dv0_r; opb = e2x_r; osub = 1'b1; end
      5'd4:  begin opa = dv1_r; opb = e1y_r; end
      5'd5:  begin opa = dv0_r; opb = e2y_r; osub = 1'b1; end
      5'd6:  begin opa = dv1_r; opb = e1z_r; end
      5'd7:  begin opa = dv0_r; opb = e2z_r; osub = 1'b1; end
      5'd8:  begin opa = du0_r; opb = e2x_r; end
      5'd9:  begin opa = du1_r; opb = e1x_r; osub = 1'b1; end
      5'd10: begin opa = du0_r; opb = e2y_r; end
      5'd11: begin opa = du1_r; opb = e1y_r; osub = 1'b1; end
      5'd12: begin opa = du0_r; opb = e2z_r; end
      5'd13: begin opa = du1_r; opb = e1z_r; osub = 1'b1; end
      5'd14: begin opa = {3'b0, c_r[0][29:0]}; opb = opa; end
      5'd15: begin opa = {3'b0, c_r[1][29:0]}; opb = opa; end
      5'd16: begin opa = {3'b0, c_r[2][29:0]}; opb = opa; end
      default: ;
    endcase
    ma = opa[32] ? 32'(-opa) : opa[31:0];
    mb = opb[32] ? 32'(-opb) : opb[31:0];
  end

  assign addend = psign_r ? -$signed({2'b00, prod_r}) : $signed({2'b00, prod_r});

  // Vector chosen for normalization.
  always_comb begin
    if (cmd.vec) begin
      vsel[0] = bx_r; vsel[1] = by_r; vsel[2] = bz_r;
    end else begin
      vsel[0] = tx_r; vsel[1] = ty_r; vsel[2] = tz_r;
    end
  end

  // Square root, divider and store helpers.
  assign lenu   = (sres_r[31:0] == 32'd0) ? 32'd1 : sres_r[31:0];
  assign strial = sres_r + sbit_r;
  assign dtrial = 47'(lenu) << cmd.qbit;
  assign ci     = cmd.comp;
  assign qneg   = (cneg_r[ci] != det_r[65]) && (q_r != 17'd0);
  assign qv     = qneg ? 16'(-q_r[15:0]) : q_r[15:0];

  assign stat.degen = (det_r == '0) ||
                      (tx_r == '0 && ty_r == '0 && tz_r == '0) ||
                      (bx_r == '0 && by_r == '0 && bz_r == '0);
  assign stat.norm_done = (mx_r[64:30] == '0) && mx_r[29];

  // Datapath registers, updated by command.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_HOLD: begin
        for (int i = 0; i < 5; i++) begin
          if (cmd.comp == 2'd0) h0_r[i] <= fin[i];
          else h1_r[i] <= fin[i];
        end
      end
      OP_LOAD: begin
        e1x_r <= 33'(h1_r[0]) - 33'(h0_r[0]);
        e1y_r <= 33'(h1_r[1]) - 33'(h0_r[1]);
        e1z_r <= 33'(h1_r[2]) - 33'(h0_r[2]);
        e2x_r <= 33'(fin[0]) - 33'(h0_r[0]);
        e2y_r <= 33'(fin[1]) - 33'(h0_r[1]);
        e2z_r <= 33'(fin[2]) - 33'(h0_r[2]);
        du0_r <= 33'(h1_r[3]) - 33'(h0_r[3]);
        dv0_r <= 33'(h1_r[4]) - 33'(h0_r[4]);
        du1_r <= 33'(fin[3]) - 33'(h0_r[3]);
        dv1_r <= 33'(fin[4]) - 33'(h0_r[4]);
        det_r <= '0; tx_r <= '0; ty_r <= '0; tz_r <= '0;
        bx_r <= '0; by_r <= '0; bz_r <= '0;
      end
      OP_MUL: begin
        prod_r  <= 64'(ma) * 64'(mb);
        psign_r <= opa[32] ^ opb[32] ^ osub;
      end
      OP_ACC: begin
        unique case (cmd.k)
          5'd0, 5'd1:   det_r <= det_r + addend;
          5'd2, 5'd3:   tx_r  <= tx_r + addend;
          5'd4, 5'd5:   ty_r  <= ty_r + addend;
          5'd6, 5'd7:   tz_r  <= tz_r + addend;
          5'd8, 5'd9:   bx_r  <= bx_r + addend;
          5'd10, 5'd11: by_r  <= by_r + addend;
          5'd12, 5'd13: bz_r  <= bz_r + addend;
          default:      sum_r <= sum_r + prod_r;
        endcase
      end
      OP_VSEL: begin
        for (int i = 0; i < 3; i++) begin
          c_r[i]    <= vsel[i][65] ? 65'(-vsel[i]) : vsel[i][64:0];
          cneg_r[i] <= vsel[i][65];
        end
        mx_r  <= vsel[0][65] ? 65'(-vsel[0]) : vsel[0][64:0];
        sum_r <= '0;
      end
      OP_MAX: begin
        if (c_r[ci] > mx_r) mx_r <= c_r[ci];
      end
      OP_NORM: begin
        // One bit a step until the largest magnitude tops out at bit 29.
        if (mx_r[64:30] != '0) begin
          mx_r <= mx_r >> 1;
          for (int i = 0; i < 3; i++) c_r[i] <= c_r[i] >> 1;
        end else begin
          mx_r <= mx_r << 1;
          for (int i = 0; i < 3; i++) c_r[i] <= c_r[i] << 1;
        end
      end
      OP_SQRT_INIT: begin
        sx_r   <= sum_r;
        sres_r <= '0;
        sbit_r <= 64'd1 << 62;
      end
      OP_SQRT_STEP: begin
        if (sx_r >= strial) begin
          sx_r   <= sx_r - strial;
          sres_r <= (sres_r >> 1) + sbit_r;
        end else begin
          sres_r <= sres_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
      end
      OP_DIV_INIT: begin
        rem_r <= 47'({c_r[ci][29:0], 14'd0}) + 47'(lenu[31:1]);
        q_r   <= '0;
      end
      OP_DIV_STEP: begin
        if (rem_r >= dtrial) begin
          rem_r <= rem_r - dtrial;
          q_r[cmd.qbit] <= 1'b1;
        end
      end
      OP_STORE: begin
        if (cmd.vec) begin
          unique case (ci)
            2'd0:    res_r[3] <= qv;
            2'd1:    res_r[4] <= qv;
            default: res_r[5] <= qv;
          endcase
        end else begin
          unique case (ci)
            2'd0:    res_r[0] <= qv;
            2'd1:    res_r[1] <= qv;
            default: res_r[2] <= qv;
          endcase
        end
      end
      OP_FIN: begin
        for (int i = 0; i < 6; i++)
          out_tdata[i*OUT_W +: OUT_W] <= stat.degen ? 16'd0 : res_r[i];
        out_tuser <= stat.degen;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/triangle_tangent_binormal.sv =====
// Top level of the triangle tangent and binormal block.
// Depends on tbn_pkg, tbn_ctrl and tbn_dp.
//
// Usage: vertices enter on the in_ channel, one beat each, three per
// triangle. The first two beats are held and give no result. The third
// beat starts the computation and gives one result beat on the out_
// channel: unit tangent and binormal in signed Q2.14, and a degenerate
// flag in out_tuser that zeroes both vectors.
// From the third vertex, the block forms the fourteen products on the
// shared 32x32 multiplier and checks for a degenerate triangle, then per
// vector finds the largest component, normalizes all three components by
// shifting until the largest tops out at bit 29, forms the sum of squares,
// takes a bit-serial square root, divides each component by the length
// and loads the result. A degenerate triangle skips the vectors and goes
// to the result load. in_tready is low while a triangle is being worked
// on. A finished result waits in the output
// register; the next triangle is accepted meanwhile and completes into it
// once out_tready takes the earlier beat. Reset (rst_n low, synchronous)
// empties the vertex count and drops out_tvalid.
`default_nettype none
module triangle_tangent_binormal (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, 32 bits each from bit 0
  input  wire logic [159:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tangent_x, tangent_y, tangent_z, binormal_x, binormal_y, binormal_z
  output logic [95:0]       out_tdata,
  // degenerate
  output logic              out_tuser
);
  import tbn_pkg::*;

  tbn_cmd_t  cmd;
  tbn_stat_t stat;

  tbn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tbn_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
`default_nettype wire
